>>> design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must never hold outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_IMPLY_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> design/owrm_pkg.sv
`default_nettype none

package owrm_pkg;

    localparam logic [7:0] CMD_READ_MEM = 8'hF0;
    localparam logic [7:0] BYTE_PASSIVE = 8'hFF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;
    localparam logic [7:0] CRC_POLY     = 8'h8C;

    localparam int OPQ_DEPTH = 4;
    localparam int OUT_DEPTH = 4;
    localparam int CFG_IDX_W = 4;
    localparam int REDIR_REGS = 4;

    typedef enum logic [1:0] {
        FN_BUS_RESET = 2'd0,
        FN_WRITE     = 2'd1,
        FN_READ      = 2'd2,
        FN_LOAD      = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_TA_LO,
        PH_TA_HI,
        PH_CRC_HDR,
        PH_DATA,
        PH_CRC_DATA,
        PH_PASSIVE
    } t_phase;

    typedef enum logic [2:0] {
        OP_LIT,
        OP_HDR,
        OP_MEM,
        OP_DFF,
        OP_DCRC,
        OP_LOAD
    } t_op_kind;

    typedef struct packed {
        t_op_kind   kind;
        logic [7:0] data;
        logic [7:0] addr;
    } t_op;

    function automatic logic [7:0] f_crc8(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> design/owrm_fifo.sv
`default_nettype none

module owrm_fifo import owrm_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [WIDTH-1:0]           i_data,
    input  wire logic                       i_pop,
    output logic      [WIDTH-1:0]           o_data,
    output logic                            o_full,
    output logic                            o_empty,
    output logic      [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wptr, n_wptr;
    logic [AW-1:0]    r_rptr, n_rptr;
    logic [CW-1:0]    r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + AW'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rptr];
    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> design/owrm_front.sv
`default_nettype none

module owrm_front import owrm_pkg::*; #(
    parameter int MEM_BYTES  = 128,
    parameter int PAGE_TOTAL = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [1:0]           i_func,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [6:0]           i_load_address,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [1:0]           i_cfg_data,
    output logic                      o_op_push,
    output t_op                       o_op
);

    localparam logic [8:0] MEM_LIM  = 9'(MEM_BYTES);
    localparam logic [2:0] PAGE_LIM = 3'(PAGE_TOTAL);

    t_phase     r_phase, n_phase;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_ta, n_ta;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_rp, n_rp;
    logic [1:0] r_redir [REDIR_REGS];

    t_func      func;
    logic [8:0] rp_inc;
    logic [2:0] page;
    logic [1:0] dest;
    logic       dest_ok;
    logic [7:0] real_addr;
    logic       real_ok;

    assign func   = t_func'(i_func);
    assign rp_inc = {1'b0, r_rp} + 9'd1;

    // page redirection
    always_comb begin
        page = r_rp[7:5];
        dest = 2'd0;
        if (!page[2] && (page < PAGE_LIM)) begin
            dest = r_redir[page[1:0]];
        end
        dest_ok   = (dest != 2'd0) && ({1'b0, dest} < PAGE_LIM);
        real_addr = dest_ok ? {1'b0, dest, r_rp[4:0]} : r_rp;
        real_ok   = ({1'b0, real_addr} < MEM_LIM);
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_cmd   = r_cmd;
        n_ta    = r_ta;
        n_crc   = r_crc;
        n_rp    = r_rp;
        if (i_accept) begin
            case (func)
                FN_BUS_RESET: begin
                    n_phase = PH_CMD;
                    n_cmd   = BYTE_ZERO;
                    n_ta    = BYTE_ZERO;
                    n_crc   = BYTE_ZERO;
                    n_rp    = BYTE_ZERO;
                end
                FN_WRITE: begin
                    case (r_phase)
                        PH_CMD: begin
                            n_cmd   = i_data_byte;
                            n_crc   = f_crc8(BYTE_ZERO, i_data_byte);
                            n_phase = PH_TA_LO;
                        end
                        PH_TA_LO: begin
                            n_ta    = i_data_byte;
                            n_crc   = f_crc8(r_crc, i_data_byte);
                            n_phase = PH_TA_HI;
                        end
                        PH_TA_HI: begin
                            n_crc = f_crc8(r_crc, i_data_byte);
                            if (r_cmd == CMD_READ_MEM && i_data_byte == BYTE_ZERO) begin
                                n_rp    = r_ta;
                                n_phase = PH_CRC_HDR;
                            end else begin
                                n_phase = PH_PASSIVE;
                            end
                        end
                        default: begin
                            n_phase = PH_PASSIVE;
                        end
                    endcase
                end
                FN_READ: begin
                    case (r_phase)
                        PH_CRC_HDR: begin
                            n_crc   = BYTE_ZERO;
                            n_phase = ({1'b0, r_rp} < MEM_LIM) ? PH_DATA : PH_CRC_DATA;
                        end
                        PH_DATA: begin
                            n_rp = rp_inc[7:0];
                            if (rp_inc >= MEM_LIM) begin
                                n_phase = PH_CRC_DATA;
                            end
                        end
                        PH_CRC_DATA: begin
                            n_phase = PH_PASSIVE;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // op generation
    always_comb begin
        o_op_push = 1'b0;
        o_op.kind = OP_LIT;
        o_op.data = BYTE_PASSIVE;
        o_op.addr = real_addr;
        if (i_accept) begin
            case (func)
                FN_LOAD: begin
                    o_op_push = ({2'b00, i_load_address} < MEM_LIM);
                    o_op.kind = OP_LOAD;
                    o_op.data = i_data_byte;
                    o_op.addr = {1'b0, i_load_address};
                end
                FN_READ: begin
                    o_op_push = 1'b1;
                    case (r_phase)
                        PH_CRC_HDR: begin
                            o_op.kind = OP_HDR;
                            o_op.data = r_crc;
                        end
                        PH_DATA: begin
                            o_op.kind = real_ok ? OP_MEM : OP_DFF;
                        end
                        PH_CRC_DATA: begin
                            o_op.kind = OP_DCRC;
                        end
                        default: begin
                            o_op.kind = OP_LIT;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_CMD;
            r_cmd   <= '0;
            r_ta    <= '0;
            r_crc   <= '0;
            r_rp    <= '0;
        end else begin
            r_phase <= n_phase;
            r_cmd   <= n_cmd;
            r_ta    <= n_ta;
            r_crc   <= n_crc;
            r_rp    <= n_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REDIR_REGS; i++) begin
                r_redir[i] <= 2'd0;
            end
        end else if (i_cfg_wr_en && (i_cfg_index < CFG_IDX_W'(REDIR_REGS))) begin
            r_redir[i_cfg_index[1:0]] <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

>>> design/owrm_back.sv
`default_nettype none

`include "assert_macros.svh"

module owrm_back import owrm_pkg::*; #(
    parameter int MEM_BYTES = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_opq_empty,
    input  wire t_op  i_op,
    output logic      o_opq_pop,
    input  wire logic i_pop,
    output logic      o_empty,
    output logic [7:0] o_read_byte
);

    localparam int MAW = $clog2(MEM_BYTES);
    localparam int OCW = $clog2(OUT_DEPTH + 1);
    localparam logic [OCW:0] OUT_LIM = (OCW + 1)'(OUT_DEPTH);

    logic [7:0]  r_mem [MEM_BYTES];
    logic [7:0]  r_rdata;
    logic        r_s1_valid;
    t_op_kind    r_s1_kind;
    logic [7:0]  r_s1_data;
    logic [7:0]  r_dcrc, n_dcrc;

    logic [7:0]     s1_value;
    logic           issue;
    logic           out_full;
    logic [OCW-1:0] out_count;
    logic [MAW-1:0] mem_idx;

    assign mem_idx   = i_op.addr[MAW-1:0];
    assign issue     = !i_opq_empty &&
                       (({1'b0, out_count} + (OCW + 1)'(r_s1_valid)) < OUT_LIM);
    assign o_opq_pop = issue;

    always_ff @(posedge i_clk) begin
        if (issue && i_op.kind == OP_LOAD) begin
            r_mem[mem_idx] <= i_op.data;
        end
        if (issue && i_op.kind == OP_MEM) begin
            r_rdata <= r_mem[mem_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_dcrc     <= '0;
        end else begin
            r_s1_valid <= issue && (i_op.kind != OP_LOAD);
            r_dcrc     <= n_dcrc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_kind <= i_op.kind;
            r_s1_data <= i_op.data;
        end
    end

    always_comb begin
        case (r_s1_kind)
            OP_MEM:  s1_value = r_rdata;
            OP_DFF:  s1_value = BYTE_PASSIVE;
            OP_DCRC: s1_value = r_dcrc;
            default: s1_value = r_s1_data;
        endcase
    end

    // data crc over returned memory bytes
    always_comb begin
        n_dcrc = r_dcrc;
        if (r_s1_valid) begin
            case (r_s1_kind)
                OP_HDR:  n_dcrc = BYTE_ZERO;
                OP_MEM:  n_dcrc = f_crc8(r_dcrc, s1_value);
                OP_DFF:  n_dcrc = f_crc8(r_dcrc, s1_value);
                default: n_dcrc = r_dcrc;
            endcase
        end
    end

    owrm_fifo #(
        .WIDTH (8),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_value),
        .i_pop   (i_pop && !o_empty),
        .o_data  (o_read_byte),
        .o_full  (out_full),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    `ASSERT_NEVER(a_s1_into_full, i_clk, i_rst_n, r_s1_valid && out_full)
    `ASSERT_IMPLY(a_issue_has_op, i_clk, i_rst_n, issue, !i_opq_empty)
    `ASSERT_IMPLY_NEXT(a_hdr_clears_crc, i_clk, i_rst_n,
        r_s1_valid && r_s1_kind == OP_HDR, r_dcrc == BYTE_ZERO)

endmodule

`default_nettype wire

>>> design/onewire_eprom_read_memory_top.sv
`default_nettype none

// channel   | direction | handshake    | payload
// input     | in        | push / full  | i_func, i_data_byte, i_load_address
// result    | out       | pop / empty  | o_read_byte
// config    | in        | i_cfg_wr_en  | i_cfg_index, i_cfg_data
//
// one transaction per cycle in while full is low, one per cycle out while empty is low; a
// read is classified in the front in the accept cycle, then passes through the op queue
// and the back (a registered memory read, then crc/select into the result queue) before it shows at the output
// a four-entry op queue and a four-entry result queue decouple the two sides
// full rises only when the op queue is full; a stalled pop backs up into it
// reset is synchronous active low; memory contents are not cleared

`include "assert_macros.svh"

module onewire_eprom_read_memory_top import owrm_pkg::*; #(
    parameter int MEM_BYTES  = 128,
    parameter int PAGE_TOTAL = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic [1:0]           i_func,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [6:0]           i_load_address,
    input  wire logic                 pop,
    output logic                      empty,
    output logic      [7:0]           o_read_byte,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [1:0]           i_cfg_data
);

    localparam int OPW = $bits(t_op);
    localparam int QCW = $clog2(OPQ_DEPTH + 1);

    logic           accept;
    logic           op_push;
    t_op            op_in;
    t_op            op_out;
    logic [OPW-1:0] op_out_bits;
    logic           opq_empty;
    logic           opq_pop;
    logic [QCW-1:0] opq_count;

    assign accept = push && !full;
    assign op_out = t_op'(op_out_bits);

    owrm_front #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_TOTAL (PAGE_TOTAL)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_load_address (i_load_address),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_op_push      (op_push),
        .o_op           (op_in)
    );

    owrm_fifo #(
        .WIDTH (OPW),
        .DEPTH (OPQ_DEPTH)
    ) u_opq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .i_pop   (opq_pop),
        .o_data  (op_out_bits),
        .o_full  (full),
        .o_empty (opq_empty),
        .o_count (opq_count)
    );

    owrm_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_opq_empty (opq_empty),
        .i_op        (op_out),
        .o_opq_pop   (opq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_read_byte (o_read_byte)
    );

    `ASSERT_IMPLY(a_queue_consistent, i_clk, i_rst_n, opq_empty, opq_count == '0)
    `ASSERT_NEVER(a_no_push_when_full, i_clk, i_rst_n, op_push && full)
    `ASSERT_IMPLY(a_pop_not_empty, i_clk, i_rst_n, opq_pop, opq_count != '0)

endmodule

`default_nettype wire

>>> verif/onewire_eprom_read_memory_top_test.sv
`default_nettype none

module onewire_eprom_read_memory_top_test import owrm_pkg::*;;

    localparam int MEM_BYTES      = 128;
    localparam int PAGE_TOTAL     = 4;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 push           = 1'b0;
    logic                 full;
    logic [1:0]           i_func         = FN_BUS_RESET;
    logic [7:0]           i_data_byte    = BYTE_ZERO;
    logic [6:0]           i_load_address = '0;
    logic                 pop            = 1'b0;
    logic                 empty;
    logic [7:0]           o_read_byte;
    logic                 i_cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index    = '0;
    logic [1:0]           i_cfg_data     = '0;

    // predicted state of the memory function
    t_phase      bus_phase = PH_CMD;
    logic [7:0]  cmd_seen  = BYTE_ZERO;
    logic [7:0]  addr_seen = BYTE_ZERO;
    logic [7:0]  crc_acc   = BYTE_ZERO;
    logic [7:0]  rd_ptr    = BYTE_ZERO;
    logic [7:0]  mem_image [MEM_BYTES];
    logic [1:0]  page_map [REDIR_REGS] = '{default: 2'd0};
    logic [7:0]  expected_read_bytes [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned counted_items  = 0;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles   = 0;

    onewire_eprom_read_memory_top #(
        .MEM_BYTES  (MEM_BYTES),
        .PAGE_TOTAL (PAGE_TOTAL)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_data_byte    (i_data_byte),
        .i_load_address (i_load_address),
        .pop            (pop),
        .empty          (empty),
        .o_read_byte    (o_read_byte),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // dallas crc8, bit serial, lsb first
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 0; i < 8; i++) begin
            fb  = acc[0] ^ b[i];
            acc = {1'b0, acc[7:1]} ^ (fb ? CRC_POLY : BYTE_ZERO);
        end
        return acc;
    endfunction

    function automatic logic [7:0] redirected_byte(input logic [7:0] addr);
        int unsigned page;
        int unsigned dest;
        int unsigned phys_addr;
        page      = addr >> 5;
        dest      = 0;
        phys_addr = addr;
        if (page < REDIR_REGS && page < PAGE_TOTAL)
            dest = page_map[page];
        if (dest != 0 && dest < PAGE_TOTAL)
            phys_addr = (addr & 32'h1F) | (dest << 5);
        if (phys_addr >= MEM_BYTES)
            return BYTE_PASSIVE;
        return mem_image[phys_addr];
    endfunction

    // returns 1 for a write in the passive phase, which leaves everything unchanged
    function automatic bit track_item(input t_func f, input logic [7:0] d,
                                      input logic [6:0] la);
        logic [7:0] rb;
        case (f)
            FN_BUS_RESET: begin
                bus_phase = PH_CMD;
                cmd_seen  = BYTE_ZERO;
                addr_seen = BYTE_ZERO;
                crc_acc   = BYTE_ZERO;
                rd_ptr    = BYTE_ZERO;
            end
            FN_LOAD: begin
                if (la < MEM_BYTES)
                    mem_image[la] = d;
            end
            FN_WRITE: begin
                case (bus_phase)
                    PH_CMD: begin
                        cmd_seen  = d;
                        crc_acc   = crc8_step(BYTE_ZERO, d);
                        bus_phase = PH_TA_LO;
                    end
                    PH_TA_LO: begin
                        addr_seen = d;
                        crc_acc   = crc8_step(crc_acc, d);
                        bus_phase = PH_TA_HI;
                    end
                    PH_TA_HI: begin
                        crc_acc = crc8_step(crc_acc, d);
                        if (cmd_seen == CMD_READ_MEM && d == BYTE_ZERO) begin
                            rd_ptr    = addr_seen;
                            bus_phase = PH_CRC_HDR;
                        end else begin
                            bus_phase = PH_PASSIVE;
                        end
                    end
                    PH_PASSIVE: return 1'b1;
                    default: bus_phase = PH_PASSIVE;
                endcase
            end
            default: begin
                rb = BYTE_PASSIVE;
                case (bus_phase)
                    PH_CRC_HDR: begin
                        rb        = crc_acc;
                        crc_acc   = BYTE_ZERO;
                        bus_phase = (rd_ptr < MEM_BYTES) ? PH_DATA : PH_CRC_DATA;
                    end
                    PH_DATA: begin
                        rb      = redirected_byte(rd_ptr);
                        crc_acc = crc8_step(crc_acc, rb);
                        rd_ptr  = rd_ptr + 8'd1;
                        if (rd_ptr >= MEM_BYTES || rd_ptr == BYTE_ZERO)
                            bus_phase = PH_CRC_DATA;
                    end
                    PH_CRC_DATA: begin
                        rb        = crc_acc;
                        bus_phase = PH_PASSIVE;
                    end
                    default: ;
                endcase
                expected_read_bytes.push_back(rb);
            end
        endcase
        return 1'b0;
    endfunction

    // result side: random pop stalls and the check of each read byte
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (expected_read_bytes.size() == 0) begin
                $error("read_byte with no transaction expected: actual %02h", o_read_byte);
                mismatch_count++;
            end else begin
                if (o_read_byte !== expected_read_bytes[0]) begin
                    $error("read_byte mismatch: expected %02h actual %02h",
                           expected_read_bytes[0], o_read_byte);
                    mismatch_count++;
                end
                void'(expected_read_bytes.pop_front());
            end
        end
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("** onewire_eprom_read_memory_top: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input t_func f, input logic [7:0] d, input logic [6:0] la);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push           <= 1'b1;
        i_func         <= f;
        i_data_byte    <= d;
        i_load_address <= la;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        if (!track_item(f, d, la))
            counted_items++;
    endtask

    task automatic bus_reset();
        send_item(FN_BUS_RESET, 8'($urandom), 7'($urandom));
    endtask

    task automatic write_byte(input logic [7:0] d);
        send_item(FN_WRITE, d, 7'($urandom));
    endtask

    task automatic read_slot();
        send_item(FN_READ, 8'($urandom), 7'($urandom));
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(posedge i_clk);
        while (expected_read_bytes.size() != 0)
            @(posedge i_clk);
    endtask

    // loads and writes leave no result, so give the pipeline time to empty
    task automatic wait_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_redirects(input logic [1:0] p0, input logic [1:0] p1,
                                     input logic [1:0] p2, input logic [1:0] p3);
        logic [1:0] vals [REDIR_REGS];
        vals = '{p0, p1, p2, p3};
        for (int i = 0; i < REDIR_REGS; i++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(i);
            i_cfg_data  <= vals[i];
            @(posedge i_clk);
            page_map[i] = vals[i];
        end
        // index past the last register, must be ignored
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_IDX_W'($urandom_range(REDIR_REGS, (1 << CFG_IDX_W) - 1));
        i_cfg_data  <= 2'($urandom);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic test_memory_preload();
        for (int a = 0; a < MEM_BYTES; a++) begin
            if (a == 0)
                send_item(FN_LOAD, BYTE_ZERO, 7'(a));
            else if (a == MEM_BYTES - 1)
                send_item(FN_LOAD, BYTE_PASSIVE, 7'(a));
            else
                send_item(FN_LOAD, 8'($urandom), 7'(a));
        end
    endtask

    task automatic test_read_to_end();
        bus_reset();
        read_slot();
        write_byte(CMD_READ_MEM);
        read_slot();
        write_byte(8'h7C);
        write_byte(BYTE_ZERO);
        repeat (7) read_slot();
    endtask

    task automatic test_rejected_headers();
        bus_reset();
        write_byte(8'h0F);
        write_byte(8'h10);
        write_byte(BYTE_ZERO);
        read_slot();
        bus_reset();
        write_byte(CMD_READ_MEM);
        write_byte(8'h10);
        write_byte(BYTE_PASSIVE);
        write_byte(8'h55);
        read_slot();
    endtask

    task automatic test_abort_and_high_target();
        bus_reset();
        write_byte(CMD_READ_MEM);
        write_byte(8'h7E);
        write_byte(BYTE_ZERO);
        repeat (2) read_slot();
        write_byte(8'hAA);
        read_slot();
        bus_reset();
        write_byte(CMD_READ_MEM);
        write_byte(BYTE_PASSIVE);
        write_byte(BYTE_ZERO);
        repeat (3) read_slot();
    endtask

    task automatic test_page_redirection();
        wait_idle();
        program_redirects(2'd3, 2'd0, 2'd1, 2'd2);
        bus_reset();
        write_byte(CMD_READ_MEM);
        write_byte(8'h1E);
        write_byte(BYTE_ZERO);
        repeat (5) read_slot();
    endtask

    task automatic test_random_traffic(input int unsigned budget, input int unsigned send_pct,
                                       input int unsigned recv_pct, input bit hold_midway);
        int unsigned start_count;
        int unsigned reads;
        logic [7:0]  lo;
        bit          paused;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_count   = counted_items;
        paused        = 1'b0;
        while (counted_items - start_count < budget) begin
            if (hold_midway && !paused && counted_items - start_count >= budget / 2) begin
                wait_drained();
                paused = 1'b1;
            end
            if ($urandom_range(99) < 80) begin
                bus_reset();
                write_byte(($urandom_range(9) == 0) ? 8'($urandom) : CMD_READ_MEM);
                case ($urandom_range(9))
                    0, 1:    lo = 8'($urandom);
                    2:       lo = 8'($urandom_range(128, 255));
                    default: lo = 8'($urandom_range(96, 127));
                endcase
                write_byte(lo);
                write_byte(($urandom_range(9) == 0) ? 8'($urandom) : BYTE_ZERO);
                reads = ($urandom_range(7) == 0) ? $urandom_range(0, 140)
                                                 : $urandom_range(0, 40);
                repeat (reads) begin
                    if ($urandom_range(11) == 0)
                        send_item(FN_LOAD, 8'($urandom), 7'($urandom));
                    read_slot();
                end
                if ($urandom_range(4) == 0) begin
                    write_byte(8'($urandom));
                    repeat ($urandom_range(1, 2)) read_slot();
                end
            end else begin
                repeat ($urandom_range(1, 6))
                    send_item(t_func'($urandom_range(3)), 8'($urandom), 7'($urandom));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 18;
        recv_idle_pct = 60;
        test_memory_preload();
        test_read_to_end();
        test_rejected_headers();
        test_abort_and_high_target();
        test_page_redirection();

        wait_idle();
        program_redirects(2'd3, 2'd3, 2'd3, 2'd3);
        test_random_traffic(330, 18, 60, 1'b1);

        wait_idle();
        program_redirects(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
        test_random_traffic(330, 60, 18, 1'b0);

        wait_idle();
        program_redirects(2'd0, 2'd0, 2'd0, 2'd0);
        test_random_traffic(330, 0, 0, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** onewire_eprom_read_memory_top: PASSED **");
        else
            $display("** onewire_eprom_read_memory_top: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
